### hw/rtl/mxt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared sizes, status codes, function codes and the compare control type of the min extract table.
// ----------------------------------------------------------------------------
package mxt_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned KeyW     = 31;
  localparam int unsigned StatW    = 2;
  localparam int unsigned LeftW    = 9;

  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StEmpty = 2'd1;
  localparam logic [StatW-1:0] StFull  = 2'd2;

  localparam logic FuncInsert  = 1'b0;
  localparam logic FuncExtract = 1'b1;

  // drives the shared compare unit for one scan beat
  typedef struct packed {
    logic            en;
    logic            first;
    logic [IdxW-1:0] idx;
  } cmp_ctrl_t;

endpackage

### hw/rtl/min_extract_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_extract_table
// Unordered key table with insert and extract-minimum operations.
// ----------------------------------------------------------------------------
// One beat in, one result beat out. An insert goes from idle straight to the
// finish state. An extract scans the table first: the single key RAM read
// port delivers one entry per cycle to the shared comparator, then the move
// state fills the hole with the last entry and the finish state loads the
// result register once it is free.
// The result register lets the next item be accepted while a result waits.
// Extract on an empty table and insert on a full one change nothing and
// report a status code.
module min_extract_table import mxt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [KeyW-1:0]  key_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [KeyW-1:0]  key_out_o,
  output logic [StatW-1:0] status_o,
  output logic [LeftW-1:0] entries_left_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SMove = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [KeyW-1:0]  last_key_q;
  logic [KeyW-1:0]  res_key_q, res_key_d;
  logic [StatW-1:0] res_stat_q, res_stat_d;
  logic             out_valid_q;
  logic [KeyW-1:0]  out_key_q;
  logic [StatW-1:0] out_stat_q;
  logic [LeftW-1:0] out_left_q;

  logic            accept, full, empty, out_free;
  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;
  logic [KeyW-1:0] wdata, rdata;
  logic [KeyW-1:0] best_key;
  logic [IdxW-1:0] best_idx;
  logic [CntW-1:0] last_idx;
  cmp_ctrl_t       cmp_ctrl;

  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_idx   = count_q - CntW'(1);

  mxt_key_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mxt_min_unit u_min (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cmp_ctrl),
    .key_i      (rdata),
    .best_key_o (best_key),
    .best_idx_o (best_idx)
  );

  // read data in scan belongs to address rd_ptr_q - 1
  always_comb begin
    cmp_ctrl.en    = (state_q == SScan);
    cmp_ctrl.first = (rd_ptr_q == CntW'(1));
    cmp_ctrl.idx   = IdxW'(rd_ptr_q - CntW'(1));
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    res_key_d  = res_key_q;
    res_stat_d = res_stat_q;
    we         = 1'b0;
    waddr      = count_q[IdxW-1:0];
    wdata      = key_in_i;
    re         = 1'b0;
    raddr      = rd_ptr_q[IdxW-1:0];
    case (state_q)
      SIdle: begin
        if (accept) begin
          res_key_d = '0;
          state_d   = SFin;
          if (func_i == FuncInsert) begin
            if (full) begin
              res_stat_d = StFull;
            end else begin
              res_stat_d = StOk;
              we         = 1'b1;
              count_d    = count_q + CntW'(1);
            end
          end else if (empty) begin
            res_stat_d = StEmpty;
          end else begin
            re       = 1'b1;
            raddr    = '0;
            rd_ptr_d = CntW'(1);
            state_d  = SScan;
          end
        end
      end
      SScan: begin
        if (rd_ptr_q < count_q) begin
          re       = 1'b1;
          rd_ptr_d = rd_ptr_q + CntW'(1);
        end else begin
          state_d = SMove;
        end
      end
      SMove: begin
        // fill the hole with the last entry unless the minimum was the last
        if (CntW'(best_idx) < last_idx) begin
          we    = 1'b1;
          waddr = best_idx;
          wdata = last_key_q;
        end
        count_d    = last_idx;
        res_key_d  = best_key;
        res_stat_d = StOk;
        state_d    = SFin;
      end
      SFin: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      if (state_q == SFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_key_q  <= res_key_d;
    res_stat_q <= res_stat_d;
    // last scan beat carries the last live entry
    if (state_q == SScan && rd_ptr_q == count_q) begin
      last_key_q <= rdata;
    end
    if (state_q == SFin && out_free) begin
      out_key_q  <= res_key_q;
      out_stat_q <= res_stat_q;
      out_left_q <= LeftW'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_out_o      = out_key_q;
  assign status_o       = out_stat_q;
  assign entries_left_o = out_left_q;

endmodule

### hw/rtl/mxt_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxt_key_ram
// Key storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mxt_key_ram import mxt_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [KeyW-1:0] wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [KeyW-1:0] rdata_o
);

  logic [KeyW-1:0] mem_q [CAPACITY];
  logic [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mxt_min_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxt_min_unit
// Running minimum: one comparator and the best key and index seen so far.
// ----------------------------------------------------------------------------
module mxt_min_unit import mxt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmp_ctrl_t       ctrl_i,
  input  logic [KeyW-1:0] key_i,
  output logic [KeyW-1:0] best_key_o,
  output logic [IdxW-1:0] best_idx_o
);

  logic [KeyW-1:0] best_key_q;
  logic [IdxW-1:0] best_idx_q;
  logic            take;

  // strict less-than keeps the lowest index on ties
  assign take = ctrl_i.en && (ctrl_i.first || (key_i < best_key_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q <= '0;
    end else if (take) begin
      best_idx_q <= ctrl_i.idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_key_q <= key_i;
    end
  end

  assign best_key_o = best_key_q;
  assign best_idx_o = best_idx_q;

endmodule

### tb/min_extract_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_extract_table_tb
// Self-checking bench for the insert / extract-minimum key table: a queue of
// operations feeds a driver, a shadow table predicts every result beat, and a
// monitor compares each result beat with the oldest prediction while both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module min_extract_table_tb;
  import mxt_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam logic [KeyW-1:0] KeyMax = {KeyW{1'b1}};

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] key;
  } table_op_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [StatW-1:0] status;
    logic [LeftW-1:0] left;
  } table_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             func_i = FuncInsert;
  logic [KeyW-1:0]  key_in_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [KeyW-1:0]  key_out_o;
  logic [StatW-1:0] status_o;
  logic [LeftW-1:0] entries_left_o;

  // shadow of the table contents
  logic [KeyW-1:0] shadow_keys [CAPACITY];
  int unsigned     shadow_count = 0;

  table_op_t     op_q[$];
  table_result_t result_q[$];
  int unsigned   plan_level = 0;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   hold_left = 0;
  int unsigned   send_wait = 0;
  int unsigned   recv_wait = 0;
  bit            send_calm = 1'b0;
  bit            recv_calm = 1'b0;
  bit            in_fire = 1'b0;
  bit            out_fire = 1'b0;

  min_extract_table i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .key_in_i       (key_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_out_o      (key_out_o),
    .status_o       (status_o),
    .entries_left_o (entries_left_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t res;
    int unsigned   best;
    res = '{key: '0, status: StOk, left: '0};
    if (op.func == FuncInsert) begin
      if (shadow_count >= CAPACITY) begin
        res.status = StFull;
      end else begin
        shadow_keys[shadow_count] = op.key;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = StEmpty;
    end else begin
      // lowest index wins a tie
      best = 0;
      for (int unsigned i = 1; i < shadow_count; i++) begin
        if (shadow_keys[i] < shadow_keys[best]) best = i;
      end
      res.key = shadow_keys[best];
      shadow_count--;
      shadow_keys[best] = shadow_keys[shadow_count];
    end
    res.left = LeftW'(shadow_count);
    return res;
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    logic [KeyW-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KeyW'($urandom_range(0, 15));
      1: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = KeyMax;
          2: k = KeyMax - 1'b1;
          default: k = KeyW'(1);
        endcase
      end
      default: k = KeyW'($urandom);
    endcase
    return k;
  endfunction

  function automatic void plan_op(logic func, logic [KeyW-1:0] key);
    op_q.push_back('{func: func, key: key});
    if (func == FuncInsert && plan_level < CAPACITY) plan_level++;
    if (func == FuncExtract && plan_level > 0) plan_level--;
  endfunction

  function automatic void plan_mixed(int unsigned n, int unsigned insert_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < insert_pct) plan_op(FuncInsert, pick_key());
      else plan_op(FuncExtract, KeyW'($urandom));
    end
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // beat accounting, prediction and checking
  always @(posedge clk_i) begin : monitor
    table_result_t got;
    table_result_t want;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      got = '{key: key_out_o, status: status_o, left: entries_left_o};
      if (result_q.size() == 0) begin
        note_failure($sformatf("unexpected result beat: key %h status %0d left %0d",
                               got.key, got.status, got.left));
      end else begin
        want = result_q.pop_front();
        if (got.key !== want.key || got.status !== want.status || got.left !== want.left)
          note_failure($sformatf(
            "result mismatch: exp key %h status %0d left %0d, got key %h status %0d left %0d",
            want.key, want.status, want.left, got.key, got.status, got.left));
      end
    end
    if (in_fire) result_q.push_back(apply_table_op('{func: func_i, key: key_in_i}));
  end

  // cycle limit and the long receiver hold-off
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == 2000 || cycle_count == 40000) hold_left = 400;
    else if (hold_left != 0) hold_left--;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin : driver
    table_op_t op;
    if (rst_ni) begin
      if (in_valid_i && !in_fire) begin
        // payload held while stalled
      end else if (send_wait != 0) begin
        in_valid_i <= 1'b0;
        send_wait--;
      end else if (op_q.size() != 0) begin
        op = op_q.pop_front();
        func_i     <= op.func;
        key_in_i   <= op.key;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (recv_wait != 0) begin
        out_stall_i <= 1'b1;
        recv_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    // directed: empty extract, key extremes, ties, ignored key on extract
    plan_op(FuncExtract, KeyMax);
    plan_op(FuncInsert, KeyMax);
    plan_op(FuncInsert, '0);
    plan_op(FuncInsert, 31'h2AAAAAAA);
    plan_op(FuncInsert, 31'h55555555);
    plan_op(FuncInsert, KeyW'(7));
    plan_op(FuncInsert, KeyW'(7));
    plan_op(FuncInsert, KeyMax - 1'b1);
    plan_op(FuncExtract, KeyMax);
    plan_op(FuncExtract, 31'h2AAAAAAA);
    plan_op(FuncExtract, 31'h55555555);
    plan_op(FuncExtract, '0);
    plan_op(FuncInsert, KeyW'(1));
    plan_op(FuncExtract, KeyMax);
    plan_op(FuncExtract, KeyMax);
    plan_op(FuncExtract, KeyMax);
    plan_op(FuncExtract, '0);
    plan_op(FuncExtract, '0);
    plan_op(FuncExtract, KeyMax);

    // random walk around a small table, often hitting empty
    plan_mixed(300, 55);
    // fill up, bounce off the full table, then drain past empty
    while (plan_level < CAPACITY) plan_op(FuncInsert, pick_key());
    plan_mixed(3, 100);
    plan_op(FuncExtract, KeyW'($urandom));
    plan_mixed(3, 100);
    while (plan_level > 0) plan_op(FuncExtract, KeyW'($urandom));
    plan_mixed(4, 0);
    plan_mixed(300, 65);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (op_q.size() == 0 && !in_valid_i);
    wait (result_q.size() == 0);
    repeat (CAPACITY + 8) @(posedge clk_i);

    if (fail_count == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
